// ----- rtl/clns_pkg.sv -----
// shared types, codes and sequence tables for the character-lcd nibble sequencer
// no dependencies; imported by every module of the block
package clns_pkg;

    // expander port bit map
    localparam int BIT_RS = 0;
    localparam int BIT_RW = 1;
    localparam int BIT_EN = 2;
    localparam int BIT_BL = 3;

    localparam logic [3:0] WAIT_NONE   = 4'd0;
    localparam logic [3:0] WAIT_EN     = 4'd1;
    localparam logic [3:0] WAIT_NIBBLE = 4'd10;
    localparam logic [3:0] WAIT_DATA   = 4'd10;
    localparam logic [3:0] WAIT_INSTR_SHORT = 4'd11;
    localparam logic [3:0] WAIT_INSTR_LONG  = 4'd12;
    localparam logic [7:0] INSTR_SHORT_MAX  = 8'h03;

    localparam logic [3:0] INIT_LAST_UNIT = 4'd10;

    typedef enum logic [1:0] {
        CMD_INSTR     = 2'd0,
        CMD_DATA      = 2'd1,
        CMD_BACKLIGHT = 2'd2,
        CMD_INIT      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        UK_CLEAR     = 3'd0,
        UK_NIBBLE    = 3'd1,
        UK_INSTR     = 3'd2,
        UK_DATA      = 3'd3,
        UK_BACKLIGHT = 3'd4
    } unit_kind_t;

    // one unit of work: a clear, a nibble, a full byte or a backlight write
    typedef struct packed {
        unit_kind_t  kind;
        logic [7:0]  value;
        logic [3:0]  final_wait;
    } unit_t;

    typedef struct packed {
        unit_t unit;
        logic  init;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic [7:0] img;
        logic [3:0] wait_ms;
        logic       done;
    } step_out_t;

    function automatic unit_t make_unit(unit_kind_t kind, logic [7:0] value,
                                        logic [3:0] final_wait);
        unit_t u;
        begin
            u.kind       = kind;
            u.value      = value;
            u.final_wait = final_wait;
            return u;
        end
    endfunction

    // initialization program, one unit per index
    function automatic unit_t init_unit(logic [3:0] idx);
        unit_t u;
        begin
            case (idx)
                4'd0:    u = make_unit(UK_CLEAR,     8'h00, 4'd10);
                4'd1:    u = make_unit(UK_NIBBLE,    8'h03, 4'd15);
                4'd2:    u = make_unit(UK_NIBBLE,    8'h03, 4'd11);
                4'd3:    u = make_unit(UK_NIBBLE,    8'h03, 4'd11);
                4'd4:    u = make_unit(UK_NIBBLE,    8'h02, 4'd11);
                4'd5:    u = make_unit(UK_INSTR,     8'h28, 4'd12);
                4'd6:    u = make_unit(UK_INSTR,     8'h08, 4'd12);
                4'd7:    u = make_unit(UK_INSTR,     8'h01, 4'd13);
                4'd8:    u = make_unit(UK_INSTR,     8'h06, 4'd12);
                4'd9:    u = make_unit(UK_INSTR,     8'h0C, 4'd12);
                4'd10:   u = make_unit(UK_BACKLIGHT, 8'h01, 4'd0);
                default: u = make_unit(UK_CLEAR,     8'h00, 4'd10);
            endcase
            return u;
        end
    endfunction

    // next port image and wait for one byte of a unit
    function automatic step_out_t gen_byte(unit_t u, logic [2:0] phase, logic [7:0] img);
        step_out_t  r;
        logic [3:0] nib;
        logic       is_byte;
        begin
            r.img     = img;
            r.wait_ms = WAIT_NONE;
            r.done    = 1'b0;
            is_byte   = (u.kind == UK_INSTR) || (u.kind == UK_DATA);
            nib       = (is_byte && (phase < 3'd4)) ? u.value[7:4] : u.value[3:0];
            case (u.kind)
                UK_CLEAR:
                begin
                    r.img     = 8'h00;
                    r.wait_ms = u.final_wait;
                    r.done    = 1'b1;
                end
                UK_BACKLIGHT:
                begin
                    r.img[BIT_BL] = u.value[0];
                    r.wait_ms     = u.final_wait;
                    r.done        = 1'b1;
                end
                UK_NIBBLE:
                begin
                    case (phase)
                        3'd0:
                        begin
                            r.img[7:4] = nib;
                        end
                        3'd1:
                        begin
                            r.img[BIT_EN] = 1'b1;
                            r.wait_ms     = WAIT_EN;
                        end
                        default:
                        begin
                            r.img[BIT_EN] = 1'b0;
                            r.wait_ms     = u.final_wait;
                            r.done        = 1'b1;
                        end
                    endcase
                end
                UK_INSTR, UK_DATA:
                begin
                    case (phase)
                        3'd0:
                        begin
                            r.img[BIT_RS] = (u.kind == UK_DATA);
                            r.img[BIT_RW] = 1'b0;
                        end
                        3'd1, 3'd4:
                        begin
                            r.img[7:4] = nib;
                        end
                        3'd2, 3'd5:
                        begin
                            r.img[BIT_EN] = 1'b1;
                            r.wait_ms     = WAIT_EN;
                        end
                        3'd3:
                        begin
                            r.img[BIT_EN] = 1'b0;
                            r.wait_ms     = WAIT_NIBBLE;
                        end
                        default:
                        begin
                            r.img[BIT_EN] = 1'b0;
                            r.wait_ms     = u.final_wait;
                            r.done        = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    r.done = 1'b1;
                end
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/clns_front.sv -----
// front end: accepts commands, classifies them into work units, two-entry queue
// depends on clns_pkg
module clns_front
    import clns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // value
    input  logic [1:0] s_tuser,   // command
    output q_head_t    head,
    input  logic       pop
);

    cmd_entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_entry_t cls;
    logic       push;
    logic       do_pop;

    // classify the incoming command
    always_comb
    begin
        cls.init = 1'b0;
        case (cmd_t'(s_tuser))
            CMD_INSTR:
            begin
                cls.unit = make_unit(UK_INSTR, s_tdata,
                    (s_tdata <= INSTR_SHORT_MAX) ? WAIT_INSTR_SHORT : WAIT_INSTR_LONG);
            end
            CMD_DATA:
            begin
                cls.unit = make_unit(UK_DATA, s_tdata, WAIT_DATA);
            end
            CMD_BACKLIGHT:
            begin
                cls.unit = make_unit(UK_BACKLIGHT, {7'd0, s_tdata[0]}, WAIT_NONE);
            end
            default:
            begin
                cls.unit = init_unit(4'd0);
                cls.init = 1'b1;
            end
        endcase
    end

    // queue pointers and fill count
    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.entry = entry_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> (count_reg == 2'd2))
        else $error("full queue lost an entry");

endmodule

// ----- rtl/clns_back.sv -----
// back end: expands work units into expander words and holds the port image
// depends on clns_pkg
module clns_back
    import clns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_head_t     head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // expander_byte, wait_ms, zero fill
    output logic        m_tlast   // last
);

    logic       active_reg, active_next;
    unit_t      unit_reg, unit_next;
    logic [2:0] phase_reg, phase_next;
    logic       init_reg, init_next;
    logic [3:0] uidx_reg, uidx_next;
    logic [7:0] image_reg, image_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic [3:0] out_wait_reg;
    logic       out_last_reg;

    step_out_t  step;
    logic       out_space;
    logic       advance;
    logic       seq_end;
    logic       load;

    // current word of the running unit
    assign step      = gen_byte(unit_reg, phase_reg, image_reg);
    assign out_space = !out_valid_reg || m_tready;
    assign advance   = active_reg && out_space;
    assign seq_end   = step.done && (!init_reg || (uidx_reg == INIT_LAST_UNIT));
    assign load      = head.valid && (!active_reg || (advance && seq_end));
    assign pop       = load;

    // sequencer next state
    always_comb
    begin
        active_next = active_reg;
        unit_next   = unit_reg;
        phase_next  = phase_reg;
        init_next   = init_reg;
        uidx_next   = uidx_reg;
        image_next  = image_reg;
        if (advance)
        begin
            image_next = step.img;
            if (step.done)
            begin
                if (!seq_end)
                begin
                    uidx_next  = uidx_reg + 4'd1;
                    unit_next  = init_unit(uidx_reg + 4'd1);
                    phase_next = 3'd0;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                phase_next = phase_reg + 3'd1;
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            unit_next   = head.entry.unit;
            init_next   = head.entry.init;
            uidx_next   = 4'd0;
            phase_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= 3'd0;
            init_reg   <= 1'b0;
            uidx_reg   <= 4'd0;
            image_reg  <= 8'h00;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            init_reg   <= init_next;
            uidx_reg   <= uidx_next;
            image_reg  <= image_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= step.img;
            out_wait_reg <= step.wait_ms;
            out_last_reg <= seq_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_wait_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    a_rw_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !image_reg[BIT_RW])
        else $error("read/write bit set in port image");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (phase_reg <= 3'd6))
        else $error("phase out of range");

    a_uidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && init_reg) |-> (uidx_reg <= INIT_LAST_UNIT))
        else $error("init unit index out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> !advance || !$past(advance) || out_valid_reg)
        else $error("output register overwritten while stalled");

endmodule

// ----- rtl/char_lcd_nibble_sequencer_core.sv -----
// character-lcd nibble sequencer: an accepted command passes the command queue, the
// sequencer state and the output register before its first expander word goes out,
// then one word per cycle while m_tready is high
// instruction and data commands give 7 words, backlight 1, initialization 49
// reset clears the command queue, the port image and the output valid
// depends on clns_pkg, clns_front, clns_back
module char_lcd_nibble_sequencer_core
    import clns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // value
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // expander_byte [7:0], wait_ms [11:8], zero [15:12]
    output logic        m_tlast    // last
);

    q_head_t head;
    logic    pop;

    // command intake and queue
    clns_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    // word sequencer
    clns_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
